// ----- rtl/lanc_pkg.sv -----
// ---------------------------------------------------------------------------
// LMS noise canceller package
// Shared word types, register indexes, sequencer states and a saturation helper.
// ---------------------------------------------------------------------------
package lanc_pkg;

    localparam int DATA_W     = 16;
    localparam int WEIGHT_W   = 24;
    localparam int STEP_W     = 16;
    localparam int LIMIT_W    = 23;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 23;
    localparam int SAT_W      = 32;

    localparam logic [STEP_W-1:0]  STEP_RESET  = 16'd655;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 23'd4194304;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP_SIZE    = 1'b0,
        CFG_WEIGHT_LIMIT = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILT,
        ST_ROUND,
        ST_ERR,
        ST_UPD
    } t_state;

    typedef struct packed {
        logic signed [DATA_W-1:0] desired_sample;
        logic signed [DATA_W-1:0] reference_sample;
    } t_in_word;

    typedef struct packed {
        logic signed [DATA_W-1:0] error_sample;
        logic signed [DATA_W-1:0] filter_output;
    } t_out_word;

    // saturate to Q1.15
    function automatic logic signed [DATA_W-1:0] sat_q15(input logic signed [SAT_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > 32'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -32'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

// ----- rtl/lanc_hist.sv -----
// ---------------------------------------------------------------------------
// LMS noise canceller sample history
// Circular buffer of reference samples; tap 0 is the newest. Taps not yet
// filled since reset read as zero through a fill count.
// ---------------------------------------------------------------------------
module lanc_hist #(
    parameter int TAP_COUNT = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_push,
    input  logic signed [lanc_pkg::DATA_W-1:0]     i_sample,
    input  logic                                   i_rd_en,
    input  logic [$clog2(TAP_COUNT)-1:0]           i_rd_tap,
    output logic signed [lanc_pkg::DATA_W-1:0]     o_rd_data
);

    localparam int IDX_W = $clog2(TAP_COUNT);
    localparam int CNT_W = $clog2(TAP_COUNT + 1);
    localparam logic [IDX_W:0]   DEPTH    = (IDX_W + 1)'(TAP_COUNT);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TAP_COUNT - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TAP_COUNT);

    logic signed [lanc_pkg::DATA_W-1:0] r_mem [TAP_COUNT];
    logic signed [lanc_pkg::DATA_W-1:0] r_q;
    logic [IDX_W-1:0] r_head;
    logic [IDX_W-1:0] n_head;
    logic [CNT_W-1:0] r_fill;
    logic [CNT_W-1:0] n_fill;
    logic             r_q_valid;
    logic [IDX_W:0]   addr_sum;
    logic [IDX_W-1:0] rd_addr;

    always_comb begin
        n_head = (r_head == '0) ? LAST_IDX : r_head - 1'b1;
        n_fill = (r_fill == FULL_CNT) ? r_fill : r_fill + 1'b1;
    end

    // tap i sits i entries past the head, wrapping at the depth
    always_comb begin
        addr_sum = {1'b0, r_head} + {1'b0, i_rd_tap};
        if (addr_sum >= DEPTH) begin
            addr_sum = addr_sum - DEPTH;
        end
        rd_addr = addr_sum[IDX_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_fill    <= '0;
            r_q_valid <= 1'b0;
        end else begin
            if (i_push) begin
                r_head <= n_head;
                r_fill <= n_fill;
            end
            if (i_rd_en) begin
                r_q_valid <= CNT_W'(i_rd_tap) < r_fill;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[n_head] <= i_sample;
        end
        if (i_rd_en) begin
            r_q <= r_mem[rd_addr];
        end
    end

    assign o_rd_data = r_q_valid ? r_q : '0;

endmodule

// ----- rtl/lanc_wmem.sv -----
// ---------------------------------------------------------------------------
// LMS noise canceller weight store
// One read and one write port. Every entry reads as zero until the first
// update pass has written the whole store in ascending order.
// ---------------------------------------------------------------------------
module lanc_wmem #(
    parameter int TAP_COUNT = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_rd_en,
    input  logic [$clog2(TAP_COUNT)-1:0]           i_rd_idx,
    output logic signed [lanc_pkg::WEIGHT_W-1:0]   o_rd_data,
    input  logic                                   i_wr_en,
    input  logic [$clog2(TAP_COUNT)-1:0]           i_wr_idx,
    input  logic signed [lanc_pkg::WEIGHT_W-1:0]   i_wr_data
);

    localparam int IDX_W = $clog2(TAP_COUNT);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TAP_COUNT - 1);

    logic signed [lanc_pkg::WEIGHT_W-1:0] r_mem [TAP_COUNT];
    logic signed [lanc_pkg::WEIGHT_W-1:0] r_q;
    logic r_primed;
    logic r_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primed  <= 1'b0;
            r_q_valid <= 1'b0;
        end else begin
            if (i_wr_en && i_wr_idx == LAST_IDX) begin
                r_primed <= 1'b1;
            end
            if (i_rd_en) begin
                r_q_valid <= r_primed;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_q <= r_mem[i_rd_idx];
        end
    end

    assign o_rd_data = r_q_valid ? r_q : '0;

endmodule

// ----- rtl/lms_adaptive_noise_canceller.sv -----
// ---------------------------------------------------------------------------
// LMS adaptive noise canceller
// Fixed-point LMS FIR: filter pass, error, then weight update pass.
// ---------------------------------------------------------------------------
// Each input word (desired and reference sample, Q1.15) yields one output
// word (error and filter output, both saturated Q1.15). Tap history and
// Q2.22 weights live in two single-port-read memories; one shared MAC
// pipeline walks all taps twice per word, once for the dot product and once
// for the weight update, with one read per cycle of each memory. The next
// input is accepted only after the update pass, and the result is loaded
// only when the output register is empty or being read out. Input stall
// is high from acceptance until the update pass drains; a finished result
// waits in the output register while the next word is taken. No clearing
// pass is needed after reset. Registers are step_size (index 0) and
// weight_limit (index 1); write them only while the block is idle.
// ---------------------------------------------------------------------------
module lms_adaptive_noise_canceller #(
    parameter int TAP_COUNT = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    input  lanc_pkg::t_in_word                    i_in_data,
    output logic                                  o_in_stall,
    output logic                                  o_out_valid,
    output lanc_pkg::t_out_word                   o_out_data,
    input  logic                                  i_out_stall,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [lanc_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [lanc_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    localparam int IDX_W  = $clog2(TAP_COUNT);
    localparam int PROD_W = lanc_pkg::WEIGHT_W + lanc_pkg::DATA_W;
    localparam int ACC_W  = PROD_W + IDX_W;
    localparam int Y_W    = ACC_W - 21;
    localparam int E_W    = Y_W + 1;
    localparam int M1_W   = 2 * lanc_pkg::DATA_W;
    localparam int P_W    = M1_W + lanc_pkg::STEP_W + 1;
    localparam int DLT_W  = P_W + 1 - 24;
    localparam int WS_W   = DLT_W + 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TAP_COUNT - 1);

    lanc_pkg::t_state r_state;
    lanc_pkg::t_state n_state;

    logic in_acc;
    logic out_free;
    logic issue;
    logic load_out;
    logic pass_done;

    logic [lanc_pkg::STEP_W-1:0]  r_step;
    logic [lanc_pkg::LIMIT_W-1:0] r_limit;

    logic [IDX_W-1:0] r_idx;
    logic             r_issue_done;
    logic             r_v1, r_v2, r_v3, r_v4;
    logic [IDX_W-1:0] r_tap1, r_tap2, r_tap3, r_tap4;

    logic signed [lanc_pkg::DATA_W-1:0]   r_d;
    logic signed [lanc_pkg::DATA_W-1:0]   h_q;
    logic signed [lanc_pkg::WEIGHT_W-1:0] w_q;

    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W:0]    acc_rnd;
    logic signed [Y_W-1:0]    r_y;
    logic signed [E_W-1:0]    e_full;
    logic signed [lanc_pkg::DATA_W-1:0] e_sat;
    logic signed [lanc_pkg::DATA_W-1:0] y_sat;
    logic signed [lanc_pkg::DATA_W-1:0] r_esat;

    logic signed [M1_W-1:0]  r_m1;
    logic signed [P_W-1:0]   r_p;
    logic signed [P_W:0]     p_rnd;
    logic signed [DLT_W-1:0] r_delta;
    logic signed [lanc_pkg::WEIGHT_W-1:0] r_w1, r_w2, r_w3;
    logic signed [WS_W-1:0]  w_sum;
    logic signed [WS_W-1:0]  lim_pos;
    logic signed [lanc_pkg::WEIGHT_W-1:0] w_new;
    logic                    w_wr_en;

    lanc_pkg::t_out_word r_out_data;
    logic                r_out_valid;

    // ---------------- configuration ----------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= lanc_pkg::STEP_RESET;
            r_limit <= lanc_pkg::LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (lanc_pkg::t_cfg_idx'(i_cfg_index))
                lanc_pkg::CFG_STEP_SIZE:    r_step  <= i_cfg_data[lanc_pkg::STEP_W-1:0];
                lanc_pkg::CFG_WEIGHT_LIMIT: r_limit <= i_cfg_data[lanc_pkg::LIMIT_W-1:0];
            endcase
        end
    end

    // ---------------- sequencer ----------------
    assign in_acc    = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign pass_done = r_issue_done && !r_v1 && !r_v2 && !r_v3 && !r_v4;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lanc_pkg::ST_IDLE:  if (in_acc) n_state = lanc_pkg::ST_FILT;
            lanc_pkg::ST_FILT:  if (pass_done) n_state = lanc_pkg::ST_ROUND;
            lanc_pkg::ST_ROUND: n_state = lanc_pkg::ST_ERR;
            lanc_pkg::ST_ERR:   if (out_free) n_state = lanc_pkg::ST_UPD;
            lanc_pkg::ST_UPD:   if (pass_done) n_state = lanc_pkg::ST_IDLE;
            default:            n_state = lanc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = (r_state != lanc_pkg::ST_IDLE);
        issue      = (r_state == lanc_pkg::ST_FILT || r_state == lanc_pkg::ST_UPD)
                     && !r_issue_done;
        load_out   = (r_state == lanc_pkg::ST_ERR) && out_free;
        w_wr_en    = (r_state == lanc_pkg::ST_UPD) && r_v4;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= lanc_pkg::ST_IDLE;
            r_idx        <= '0;
            r_issue_done <= 1'b1;
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
            r_v3         <= 1'b0;
            r_v4         <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_acc || load_out) begin
                r_idx        <= '0;
                r_issue_done <= 1'b0;
            end else if (issue) begin
                if (r_idx == LAST_IDX) begin
                    r_issue_done <= 1'b1;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            r_v1 <= issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------- memories ----------------
    lanc_hist #(
        .TAP_COUNT (TAP_COUNT)
    ) u_hist (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (in_acc),
        .i_sample  (i_in_data.reference_sample),
        .i_rd_en   (issue),
        .i_rd_tap  (r_idx),
        .o_rd_data (h_q)
    );

    lanc_wmem #(
        .TAP_COUNT (TAP_COUNT)
    ) u_wmem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (issue),
        .i_rd_idx  (r_idx),
        .o_rd_data (w_q),
        .i_wr_en   (w_wr_en),
        .i_wr_idx  (r_tap4),
        .i_wr_data (w_new)
    );

    // ---------------- MAC pipeline ----------------
    always_comb begin
        acc_rnd = {r_acc[ACC_W-1], r_acc} + (ACC_W + 1)'(1 << 21);
        e_full  = E_W'(r_d) - E_W'(r_y);
        e_sat   = lanc_pkg::sat_q15(lanc_pkg::SAT_W'(e_full));
        y_sat   = lanc_pkg::sat_q15(lanc_pkg::SAT_W'(r_y));
        p_rnd   = {r_p[P_W-1], r_p} + (P_W + 1)'(1 << 23);
        lim_pos = $signed(WS_W'(r_limit));
        w_sum   = WS_W'(r_w3) + WS_W'(r_delta);
        if (w_sum > lim_pos) begin
            w_sum = lim_pos;
        end else if (w_sum < -lim_pos) begin
            w_sum = -lim_pos;
        end
        w_new = w_sum[lanc_pkg::WEIGHT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_d <= i_in_data.desired_sample;
        end
        // filter pass: product then accumulate
        r_prod <= w_q * h_q;
        if (in_acc) begin
            r_acc <= '0;
        end else if (r_state == lanc_pkg::ST_FILT && r_v2) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
        if (r_state == lanc_pkg::ST_ROUND) begin
            r_y <= acc_rnd[ACC_W:22];
        end
        if (load_out) begin
            r_esat                  <= e_sat;
            r_out_data.error_sample  <= e_sat;
            r_out_data.filter_output <= y_sat;
        end
        // update pass: e*x, times beta, round, add and clamp
        r_m1    <= r_esat * h_q;
        r_p     <= r_m1 * $signed({1'b0, r_step});
        r_delta <= p_rnd[P_W:24];
        r_w1    <= w_q;
        r_w2    <= r_w1;
        r_w3    <= r_w2;
        r_tap1  <= r_idx;
        r_tap2  <= r_tap1;
        r_tap3  <= r_tap2;
        r_tap4  <= r_tap3;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ----- verif/lms_adaptive_noise_canceller_test.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// LMS noise canceller testbench
// Drives sample words through the canceller under several step and limit
// settings and idle patterns, predicts each error/output word with a
// fixed-point LMS model kept in step with the block, and checks every word.
// ---------------------------------------------------------------------------
module lms_adaptive_noise_canceller_test;

    localparam int TAPS           = 32;
    localparam int DIRECTED_A     = 8;
    localparam int RAND_PER_PHASE = 100;
    localparam int RAND_PHASES    = 8;
    localparam int SETTLE_CYCLES  = 100;
    localparam longint ROUND_Y    = 64'sd2097152;  // half LSB of Q.37 -> Q.15
    localparam longint ROUND_W    = 64'sd8388608;  // half LSB of Q.46 -> Q2.22

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               in_valid_r = 1'b0;
    lanc_pkg::t_in_word                 in_word_r = '0;
    logic                               o_in_stall;
    logic                               o_out_valid;
    lanc_pkg::t_out_word                o_out_data;
    logic                               out_stall_r = 1'b1;
    logic                               cfg_valid_r = 1'b0;
    logic                               o_cfg_ready;
    logic [lanc_pkg::CFG_IDX_W-1:0]     cfg_index_r = '0;
    logic [lanc_pkg::CFG_DATA_W-1:0]    cfg_data_r = '0;

    // canceller state mirror
    logic signed [lanc_pkg::DATA_W-1:0]   hist[TAPS];
    logic signed [lanc_pkg::WEIGHT_W-1:0] wts[TAPS];
    logic [lanc_pkg::STEP_W-1:0]          step_r = lanc_pkg::STEP_RESET;
    logic [lanc_pkg::LIMIT_W-1:0]         limit_r = lanc_pkg::LIMIT_RESET;

    lanc_pkg::t_in_word                 sample_q[$];
    lanc_pkg::t_out_word                predicted_q[$];
    t_idle_mode                         idle_mode = IDLE_NONE;
    logic signed [lanc_pkg::DATA_W-1:0] prev_ref = '0;
    int                                 fail_count = 0;

    lms_adaptive_noise_canceller #(
        .TAP_COUNT (TAPS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid_r),
        .i_in_data   (in_word_r),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (out_stall_r),
        .i_cfg_valid (cfg_valid_r),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index_r),
        .i_cfg_data  (cfg_data_r)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        for (int i = 0; i < TAPS; i++) begin
            hist[i] = '0;
            wts[i]  = '0;
        end
    end

    function automatic logic signed [lanc_pkg::DATA_W-1:0] clip_q15(input longint v);
        logic signed [lanc_pkg::DATA_W-1:0] r;
        if (v > 32767) begin
            r = 16'sh7FFF;
        end else if (v < -32768) begin
            r = 16'sh8000;
        end else begin
            r = v[lanc_pkg::DATA_W-1:0];
        end
        return r;
    endfunction

    // One LMS step: shift, filter, error, weight update with clamp.
    function automatic lanc_pkg::t_out_word cancel_step(input lanc_pkg::t_in_word w);
        longint              acc;
        longint              y;
        longint              e;
        longint              e_sat;
        longint              p;
        longint              nw;
        longint              lim;
        longint              stp;
        lanc_pkg::t_out_word r;
        for (int i = TAPS - 1; i > 0; i--) begin
            hist[i] = hist[i-1];
        end
        hist[0] = w.reference_sample;
        acc = 0;
        for (int i = 0; i < TAPS; i++) begin
            acc += longint'(wts[i]) * longint'(hist[i]);
        end
        y     = (acc + ROUND_Y) >>> 22;
        e     = longint'(w.desired_sample) - y;
        e_sat = clip_q15(e);
        stp   = longint'(step_r);
        lim   = longint'(limit_r);
        for (int i = 0; i < TAPS; i++) begin
            p  = stp * e_sat * longint'(hist[i]);
            nw = longint'(wts[i]) + ((p + ROUND_W) >>> 24);
            if (nw > lim) begin
                nw = lim;
            end
            if (nw < -lim) begin
                nw = -lim;
            end
            wts[i] = nw[lanc_pkg::WEIGHT_W-1:0];
        end
        r.error_sample  = clip_q15(e);
        r.filter_output = clip_q15(y);
        return r;
    endfunction

    function automatic bit idle_roll(input bit sender);
        bit hit;
        case (idle_mode)
            IDLE_SEND: hit = sender && ($urandom_range(99) < 59);
            IDLE_RECV: hit = !sender && ($urandom_range(99) < 59);
            IDLE_BOTH: hit = ($urandom_range(99) < 6);
            default:   hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic logic signed [lanc_pkg::DATA_W-1:0] pick_extreme();
        logic signed [lanc_pkg::DATA_W-1:0] v;
        case ($urandom_range(4))
            0:       v = 16'sh7FFF;
            1:       v = 16'sh8000;
            2:       v = 16'sh0000;
            3:       v = 16'sh0001;
            default: v = 16'shFFFF;
        endcase
        return v;
    endfunction

    // In 40% of words the desired channel carries a filtered copy of the reference,
    // so the weights can converge; the rest is extremes, small and raw noise.
    function automatic lanc_pkg::t_in_word make_word();
        lanc_pkg::t_in_word                 w;
        int unsigned                        sel;
        int                                 tmp;
        logic signed [lanc_pkg::DATA_W-1:0] x;
        logic signed [lanc_pkg::DATA_W-1:0] d;
        sel = $urandom_range(99);
        x   = lanc_pkg::DATA_W'($urandom);
        d   = lanc_pkg::DATA_W'($urandom);
        if (sel < 40) begin
            tmp = int'(x >>> 1) + int'(prev_ref >>> 2) + int'($urandom_range(255)) - 128;
            d   = tmp[lanc_pkg::DATA_W-1:0];
        end else if (sel < 55) begin
            x = pick_extreme();
            d = pick_extreme();
        end else if (sel < 70) begin
            tmp = int'($urandom_range(511)) - 256;
            x   = tmp[lanc_pkg::DATA_W-1:0];
            tmp = int'($urandom_range(511)) - 256;
            d   = tmp[lanc_pkg::DATA_W-1:0];
        end
        prev_ref = x;
        w.desired_sample   = d;
        w.reference_sample = x;
        return w;
    endfunction

    task automatic queue_word(input logic [lanc_pkg::DATA_W-1:0] d,
                              input logic [lanc_pkg::DATA_W-1:0] x);
        lanc_pkg::t_in_word w;
        w.desired_sample   = d;
        w.reference_sample = x;
        sample_q.push_back(w);
    endtask

    task automatic cfg_write(input lanc_pkg::t_cfg_idx idx,
                             input logic [lanc_pkg::CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        cfg_valid_r <= 1'b1;
        cfg_index_r <= idx;
        cfg_data_r  <= val;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        cfg_valid_r <= 1'b0;
        case (idx)
            lanc_pkg::CFG_STEP_SIZE:    step_r = val[lanc_pkg::STEP_W-1:0];
            lanc_pkg::CFG_WEIGHT_LIMIT: limit_r = val[lanc_pkg::LIMIT_W-1:0];
            default:                    ;
        endcase
    endtask

    // polled mid-cycle so the edge's updates have all landed
    task automatic wait_idle();
        @(negedge i_clk);
        while (sample_q.size() != 0 || in_valid_r || predicted_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // input driver
    always @(posedge i_clk) begin : drive_p
        logic               nv;
        lanc_pkg::t_in_word nd;
        nv = in_valid_r;
        nd = in_word_r;
        if (i_rst_n) begin
            if (in_valid_r && !o_in_stall) begin
                predicted_q.push_back(cancel_step(in_word_r));
                nv = 1'b0;
            end
            if (!nv && sample_q.size() != 0 && !idle_roll(1'b1)) begin
                nd = sample_q.pop_front();
                nv = 1'b1;
            end
        end
        in_valid_r <= nv;
        in_word_r  <= nd;
    end

    // output monitor
    always @(posedge i_clk) begin : check_p
        lanc_pkg::t_out_word want;
        if (i_rst_n && o_out_valid && !out_stall_r) begin
            if (predicted_q.size() == 0) begin
                $error("unexpected output word: error_sample %0d, filter_output %0d",
                       o_out_data.error_sample, o_out_data.filter_output);
                fail_count++;
            end else begin
                want = predicted_q.pop_front();
                if (o_out_data.error_sample !== want.error_sample) begin
                    $error("error_sample mismatch: expected %0d, actual %0d",
                           want.error_sample, o_out_data.error_sample);
                    fail_count++;
                end
                if (o_out_data.filter_output !== want.filter_output) begin
                    $error("filter_output mismatch: expected %0d, actual %0d",
                           want.filter_output, o_out_data.filter_output);
                    fail_count++;
                end
            end
        end
        out_stall_r <= i_rst_n ? idle_roll(1'b0) : 1'b1;
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings, full-scale corners
        queue_word(16'h7FFF, 16'h7FFF);
        queue_word(16'h8000, 16'h8000);
        queue_word(16'h0000, 16'h0000);
        queue_word(16'h7FFF, 16'h8000);
        queue_word(16'h8000, 16'h7FFF);
        queue_word(16'h0001, 16'hFFFF);
        queue_word(16'hFFFF, 16'h0001);
        queue_word(16'h0000, 16'h7FFF);
        wait_idle();

        // max gain and limit: weights hit the clamp, y and e saturate
        cfg_write(lanc_pkg::CFG_STEP_SIZE, 23'h00FFFF);
        cfg_write(lanc_pkg::CFG_WEIGHT_LIMIT, 23'h7FFFFF);
        repeat (6) queue_word(16'h7FFF, 16'h7FFF);
        repeat (4) queue_word(16'h8000, 16'h7FFF);
        wait_idle();

        // limit lowered under large weights
        cfg_write(lanc_pkg::CFG_WEIGHT_LIMIT, 23'd100000);
        repeat (3) queue_word(16'h0000, 16'h7FFF);
        wait_idle();

        // zero limit pins every weight at zero
        cfg_write(lanc_pkg::CFG_WEIGHT_LIMIT, 23'd0);
        repeat (4) queue_word(16'h7FFF, 16'h8000);
        wait_idle();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0: begin
                    cfg_write(lanc_pkg::CFG_STEP_SIZE, 23'(lanc_pkg::STEP_RESET));
                    cfg_write(lanc_pkg::CFG_WEIGHT_LIMIT, 23'(lanc_pkg::LIMIT_RESET));
                end
                1: begin
                    cfg_write(lanc_pkg::CFG_STEP_SIZE, 23'h00FFFF);
                    cfg_write(lanc_pkg::CFG_WEIGHT_LIMIT, 23'h7FFFFF);
                end
                2: begin
                    cfg_write(lanc_pkg::CFG_STEP_SIZE, 23'd0);
                    cfg_write(lanc_pkg::CFG_WEIGHT_LIMIT, 23'h7FFFFF);
                end
                3: begin
                    cfg_write(lanc_pkg::CFG_STEP_SIZE, 23'($urandom_range(65535)));
                    cfg_write(lanc_pkg::CFG_WEIGHT_LIMIT, 23'($urandom_range(8388607)));
                end
                4: begin
                    cfg_write(lanc_pkg::CFG_STEP_SIZE, 23'h00FFFF);
                    cfg_write(lanc_pkg::CFG_WEIGHT_LIMIT, 23'd0);
                end
                5: begin
                    cfg_write(lanc_pkg::CFG_STEP_SIZE, 23'd1);
                    cfg_write(lanc_pkg::CFG_WEIGHT_LIMIT, 23'd1);
                end
                6: begin
                    cfg_write(lanc_pkg::CFG_STEP_SIZE, 23'd20000);
                    cfg_write(lanc_pkg::CFG_WEIGHT_LIMIT, 23'h7FFFFF);
                end
                default: begin
                    cfg_write(lanc_pkg::CFG_STEP_SIZE, 23'($urandom_range(65535)));
                    cfg_write(lanc_pkg::CFG_WEIGHT_LIMIT, 23'd300000);
                end
            endcase
            @(negedge i_clk);
            idle_mode = t_idle_mode'(ph % 4);
            repeat (RAND_PER_PHASE) sample_q.push_back(make_word());
            wait_idle();
        end

        if (fail_count == 0 && predicted_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #(64'd10_000_000);
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/lanc_pkg.sv
rtl/lanc_hist.sv
rtl/lanc_wmem.sv
rtl/lms_adaptive_noise_canceller.sv
verif/lms_adaptive_noise_canceller_test.sv
